// ----- rtl/imbt_pkg.sv -----
// ============================================================================
// imbt_pkg: shared types and constants of the IP/MAC binding table
// Holds the operation and status codes, the stored entry layout and the
// command and status bundles between the controller and the datapath.
// ============================================================================
package imbt_pkg;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 64;

  // Operation codes carried on in_mode
  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_LOOKUP = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_TICK   = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // Saturation limit of the removed-entry count
  localparam logic [6:0] COUNT_MAX = 7'd127;

  // One stored binding, kept as a single memory word
  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] lease;
    logic [31:0] expiry;
    logic [31:0] seq;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic init_wr;  // clearing pass: zero one entry per cycle
    logic load;     // capture the accepted item, restart the scan
    logic scan;     // issue the next table read
    logic finish;   // form the result from the scan state
    logic commit;   // final write of a delete
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cnt_end;     // scan counter has covered every entry
    logic rd_pending;  // a read is still in flight
  } stat_t;

endpackage

// ----- rtl/ip_mac_binding_table_with_aging_top.sv -----
// ============================================================================
// ip_mac_binding_table_with_aging_top: IPv4-to-MAC binding table with aging
// Bounded table of IP/MAC/lease/expiry bindings with insert, lookup, delete,
// expiry tick and clear operations.
// ============================================================================
// Usage:
//   Drive in_* and raise start while busy is low; the item transfers at that
//   clock edge. busy stays high until the result has been shown.
//   The result appears on out_* for exactly one cycle with out_valid high.
//   The receiver cannot stall; it must take the result in that cycle.
// Timing:
//   Every operation walks the whole table through the memory read port, one
//   entry per cycle, then shows its result; the next item can transfer only
//   once the result has been shown and busy has fallen.
// Reset:
//   rst_n is synchronous, active low. After reset a clearing pass zeroes
//   every table entry, one per cycle, with busy high; the sequence counter
//   restarts at zero.
// ============================================================================
module ip_mac_binding_table_with_aging_top #(
  parameter int TABLE_ENTRIES = imbt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_ip_addr,
  input  logic [47:0] in_mac_addr,
  input  logic [31:0] in_lease_secs,
  input  logic [31:0] in_expiry_sec,
  input  logic [31:0] in_now_sec,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [47:0] out_hit_mac,
  output logic [31:0] out_hit_lease,
  output logic [31:0] out_hit_expiry,
  output logic [6:0]  out_removed_count
);
  import imbt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  imbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  imbt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_mode),
    .in_ip_addr        (in_ip_addr),
    .in_mac_addr       (in_mac_addr),
    .in_lease_secs     (in_lease_secs),
    .in_expiry_sec     (in_expiry_sec),
    .in_now_sec        (in_now_sec),
    .out_status        (out_status),
    .out_hit_mac       (out_hit_mac),
    .out_hit_lease     (out_hit_lease),
    .out_hit_expiry    (out_hit_expiry),
    .out_removed_count (out_removed_count)
  );

  // A result is only shown while an operation is in progress
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside an operation");

  // The scan has fully drained before the result is shown
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!stat.rd_pending && stat.cnt_end))
    else $error("result shown with a table read in flight");

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted item did not start an operation");

  // The result strobe lasts a single cycle
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

// ----- rtl/imbt_ram.sv -----
// ============================================================================
// imbt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module imbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/imbt_ctrl.sv -----
// ============================================================================
// imbt_ctrl: operation sequencer
// Runs the clearing pass after reset, then one table scan per accepted item
// followed by a single response cycle.
// ============================================================================
module imbt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  imbt_pkg::stat_t stat,
  output imbt_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_valid
);
  import imbt_pkg::*;

  typedef enum logic [3:0] {
    S_INIT = 4'b0001,
    S_IDLE = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.cnt_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.cnt_end && !stat.rd_pending) begin
          cmd.finish = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

endmodule

// ----- rtl/imbt_dp.sv -----
// ============================================================================
// imbt_dp: binding table datapath
// Holds the table memory, the scan counter, the item registers, the best
// match tracking and the result registers.
// ============================================================================
module imbt_dp #(
  parameter int TABLE_ENTRIES = imbt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  imbt_pkg::cmd_t  cmd,
  output imbt_pkg::stat_t stat,
  input  logic [2:0]     in_mode,
  input  logic [31:0]    in_ip_addr,
  input  logic [47:0]    in_mac_addr,
  input  logic [31:0]    in_lease_secs,
  input  logic [31:0]    in_expiry_sec,
  input  logic [31:0]    in_now_sec,
  output logic [1:0]     out_status,
  output logic [47:0]    out_hit_mac,
  output logic [31:0]    out_hit_lease,
  output logic [31:0]    out_hit_expiry,
  output logic [6:0]     out_removed_count
);
  import imbt_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = AW + 1;
  localparam int EW = $bits(entry_t);

  // Item registers
  logic [2:0]  mode_r;
  logic [31:0] ip_r, lease_r, expiry_r, now_r;
  logic [47:0] mac_r;

  // Scan control
  logic [CW-1:0] cnt_r;
  logic          cnt_end;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;

  // Scan results
  logic          found_r;
  logic [AW-1:0] best_idx_r;
  logic [31:0]   best_age_r;
  logic [47:0]   best_mac_r;
  logic [31:0]   best_lease_r, best_exp_r;
  logic [6:0]    count_r;
  logic [31:0]   next_seq_r;

  // Memory ports
  logic          rd_en, wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data, rd_q, new_entry;
  logic [EW-1:0] rd_word;

  // Per-entry decisions
  logic        ins_take, rm_take, better;
  logic [31:0] age;

  // Result registers
  logic [1:0]  status_r, status_nxt;
  logic [47:0] hmac_r, hmac_nxt;
  logic [31:0] hlease_r, hlease_nxt, hexp_r, hexp_nxt;
  logic [6:0]  removed_r, removed_nxt;

  assign cnt_end         = (cnt_r == CW'(TABLE_ENTRIES));
  assign stat.cnt_end    = cnt_end;
  assign stat.rd_pending = rd_vld_r;

  assign rd_en = cmd.scan && !cnt_end;
  assign rd_q  = entry_t'(rd_word);

  imbt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_word)
  );

  // Decide what the entry now on the read port does
  always_comb begin
    new_entry = '{valid: 1'b1, ip: ip_r, mac: mac_r, lease: lease_r,
                  expiry: expiry_r, seq: next_seq_r};
    age       = next_seq_r - rd_q.seq;
    ins_take  = 1'b0;
    rm_take   = 1'b0;
    better    = 1'b0;
    if (rd_vld_r) begin
      case (mode_r)
        MODE_INSERT: ins_take = !rd_q.valid && !found_r;
        MODE_LOOKUP, MODE_DELETE: begin
          better = rd_q.valid && (rd_q.ip == ip_r) && (!found_r || (age < best_age_r));
        end
        MODE_TICK:  rm_take = rd_q.valid && (rd_q.expiry <= now_r);
        MODE_CLEAR: rm_take = rd_q.valid;
        default: ;
      endcase
    end
  end

  // Single write port: clearing pass, delete commit, or scan write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx_r;
    wr_data = '0;
    if (cmd.init_wr && !cnt_end) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r[AW-1:0];
    end else if (cmd.commit && (mode_r == MODE_DELETE) && found_r) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_r;
    end else if (ins_take) begin
      wr_en   = 1'b1;
      wr_data = new_entry;
    end else if (rm_take) begin
      wr_en   = 1'b1;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      ip_r     <= in_ip_addr;
      mac_r    <= in_mac_addr;
      lease_r  <= in_lease_secs;
      expiry_r <= in_expiry_sec;
      now_r    <= in_now_sec;
    end
  end

  // Advance the scan counter and track the read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (cmd.load) begin
        cnt_r <= '0;
      end else if ((cmd.init_wr || cmd.scan) && !cnt_end) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[AW-1:0];
  end

  // Match tracking, removed count and insertion sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      count_r    <= '0;
      next_seq_r <= '0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
      count_r <= '0;
    end else begin
      if (ins_take) begin
        found_r    <= 1'b1;
        next_seq_r <= next_seq_r + 32'd1;
      end
      if (better) begin
        found_r <= 1'b1;
      end
      if (rm_take && (count_r != COUNT_MAX)) begin
        count_r <= count_r + 7'd1;
      end
    end
  end

  // Hold the best match so far
  always_ff @(posedge clk) begin
    if (better) begin
      best_idx_r   <= rd_idx_r;
      best_age_r   <= age;
      best_mac_r   <= rd_q.mac;
      best_lease_r <= rd_q.lease;
      best_exp_r   <= rd_q.expiry;
    end
  end

  // Form the result
  always_comb begin
    status_nxt  = STAT_OK;
    hmac_nxt    = '0;
    hlease_nxt  = '0;
    hexp_nxt    = '0;
    removed_nxt = '0;
    case (mode_r)
      MODE_INSERT: status_nxt = found_r ? STAT_OK : STAT_FULL;
      MODE_LOOKUP: begin
        status_nxt = found_r ? STAT_OK : STAT_MISS;
        if (found_r) begin
          hmac_nxt   = best_mac_r;
          hlease_nxt = best_lease_r;
          hexp_nxt   = best_exp_r;
        end
      end
      MODE_DELETE: status_nxt = found_r ? STAT_OK : STAT_MISS;
      MODE_TICK, MODE_CLEAR: removed_nxt = count_r;
      default: status_nxt = STAT_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r  <= status_nxt;
      hmac_r    <= hmac_nxt;
      hlease_r  <= hlease_nxt;
      hexp_r    <= hexp_nxt;
      removed_r <= removed_nxt;
    end
  end

  assign out_status        = status_r;
  assign out_hit_mac       = hmac_r;
  assign out_hit_lease     = hlease_r;
  assign out_hit_expiry    = hexp_r;
  assign out_removed_count = removed_r;

endmodule

// ----- tb/sv/binding_table_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// binding_table_checker: result predictor and comparator for the binding table
// Watches the command and result channels of the IP/MAC binding table, keeps
// its own copy of the table and predicts one result per accepted command.
// Every result is compared field by field with the oldest prediction.
// ============================================================================
module binding_table_checker #(
  parameter int TABLE_ENTRIES = imbt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_ip_addr,
  input  logic [47:0] in_mac_addr,
  input  logic [31:0] in_lease_secs,
  input  logic [31:0] in_expiry_sec,
  input  logic [31:0] in_now_sec,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [47:0] out_hit_mac,
  input  logic [31:0] out_hit_lease,
  input  logic [31:0] out_hit_expiry,
  input  logic [6:0]  out_removed_count,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);
  import imbt_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] mac;
    logic [31:0] lease;
    logic [31:0] expiry;
    logic [6:0]  removed;
  } binding_result_t;

  // Shadow copy of the binding table
  logic        bind_valid  [TABLE_ENTRIES];
  logic [31:0] bind_ip     [TABLE_ENTRIES];
  logic [47:0] bind_mac    [TABLE_ENTRIES];
  logic [31:0] bind_lease  [TABLE_ENTRIES];
  logic [31:0] bind_expiry [TABLE_ENTRIES];
  logic [31:0] bind_seq    [TABLE_ENTRIES];
  logic [31:0] seq_next;

  binding_result_t expected_results[$];
  int unsigned     error_total = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    error_total++;
  endtask

  // Find the youngest valid binding for an address; ties go to the lowest slot
  function automatic int newest_binding(input logic [31:0] ip);
    int          best;
    logic [31:0] best_age;
    logic [31:0] age;
    best     = -1;
    best_age = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (bind_valid[i] && bind_ip[i] == ip) begin
        age = seq_next - bind_seq[i];
        if (best < 0 || age < best_age) begin
          best     = i;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  // Apply one command to the shadow table and form its result
  task automatic predict_binding_op(input logic [2:0] mode, input logic [31:0] ip,
                                    input logic [47:0] mac, input logic [31:0] lease,
                                    input logic [31:0] expiry, input logic [31:0] now,
                                    output binding_result_t res);
    int          slot;
    int unsigned n;
    res = '0;
    n   = 0;
    case (mode)
      MODE_INSERT: begin
        slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (!bind_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          bind_valid[slot]  = 1'b1;
          bind_ip[slot]     = ip;
          bind_mac[slot]    = mac;
          bind_lease[slot]  = lease;
          bind_expiry[slot] = expiry;
          bind_seq[slot]    = seq_next;
          seq_next          = seq_next + 32'd1;
        end
      end
      MODE_LOOKUP: begin
        slot = newest_binding(ip);
        if (slot < 0) begin
          res.status = STAT_MISS;
        end else begin
          res.status = STAT_OK;
          res.mac    = bind_mac[slot];
          res.lease  = bind_lease[slot];
          res.expiry = bind_expiry[slot];
        end
      end
      MODE_DELETE: begin
        slot = newest_binding(ip);
        if (slot < 0) res.status = STAT_MISS;
        else bind_valid[slot] = 1'b0;
      end
      MODE_TICK, MODE_CLEAR: begin
        // tick drops expired bindings, clear drops every binding
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (bind_valid[i] && (mode == MODE_CLEAR || bind_expiry[i] <= now)) begin
            bind_valid[i] = 1'b0;
            n++;
          end
        end
        res.status  = STAT_OK;
        res.removed = (n > COUNT_MAX) ? COUNT_MAX : 7'(n);
      end
      default: begin
        res.status = STAT_MISS;
      end
    endcase
  endtask

  // Compare results first, then queue the prediction for a new transfer
  always @(posedge clk) begin
    binding_result_t got;
    binding_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) bind_valid[i] = 1'b0;
      seq_next = '0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        got = '{out_status, out_hit_mac, out_hit_lease, out_hit_expiry,
                out_removed_count};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result status", 64'(got.status), '0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.mac !== want.mac)
            report_mismatch("hit_mac", 64'(got.mac), 64'(want.mac));
          if (got.lease !== want.lease)
            report_mismatch("hit_lease", 64'(got.lease), 64'(want.lease));
          if (got.expiry !== want.expiry)
            report_mismatch("hit_expiry", 64'(got.expiry), 64'(want.expiry));
          if (got.removed !== want.removed)
            report_mismatch("removed_count", 64'(got.removed), 64'(want.removed));
        end
      end
      if (start && !busy) begin
        predict_binding_op(in_mode, in_ip_addr, in_mac_addr, in_lease_secs,
                           in_expiry_sec, in_now_sec, want);
        expected_results.push_back(want);
      end
    end
    mismatch_count <= error_total;
    outstanding    <= expected_results.size();
  end

endmodule

// ----- tb/sv/ip_mac_binding_table_with_aging_top_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ip_mac_binding_table_with_aging_top_tb: testbench of the IP/MAC binding table
// Drives directed commands over the extremes and corner cases, then random
// command episodes that fill, churn, age and clear the table, with random
// gaps between transfers. A checker beside the block predicts and compares.
// ============================================================================
module ip_mac_binding_table_with_aging_top_tb;
  import imbt_pkg::*;

  localparam int          TABLE_ENTRIES     = TABLE_ENTRIES_DEF;
  localparam int unsigned CYCLE_LIMIT       = 1_000_000;
  localparam int          RANDOM_OPS        = 650;
  localparam int          EPISODE_LEN       = 80;
  localparam logic [2:0]  MODE_FIRST_UNUSED = MODE_CLEAR + 3'd1;
  localparam logic [2:0]  MODE_LAST_UNUSED  = 3'd7;
  localparam logic [31:0] ALL_ONES_32       = 32'hFFFF_FFFF;
  localparam logic [47:0] ALL_ONES_48       = 48'hFFFF_FFFF_FFFF;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        start             = 1'b0;
  logic [2:0]  in_mode           = MODE_LOOKUP;
  logic [31:0] in_ip_addr        = '0;
  logic [47:0] in_mac_addr       = '0;
  logic [31:0] in_lease_secs     = '0;
  logic [31:0] in_expiry_sec     = '0;
  logic [31:0] in_now_sec        = '0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [47:0] out_hit_mac;
  logic [31:0] out_hit_lease;
  logic [31:0] out_hit_expiry;
  logic [6:0]  out_removed_count;
  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count       = 0;

  ip_mac_binding_table_with_aging_top #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_ip_addr(in_ip_addr), .in_mac_addr(in_mac_addr),
    .in_lease_secs(in_lease_secs), .in_expiry_sec(in_expiry_sec),
    .in_now_sec(in_now_sec), .out_valid(out_valid), .out_status(out_status),
    .out_hit_mac(out_hit_mac), .out_hit_lease(out_hit_lease),
    .out_hit_expiry(out_hit_expiry), .out_removed_count(out_removed_count)
  );

  binding_table_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_ip_addr(in_ip_addr), .in_mac_addr(in_mac_addr),
    .in_lease_secs(in_lease_secs), .in_expiry_sec(in_expiry_sec),
    .in_now_sec(in_now_sec), .out_valid(out_valid), .out_status(out_status),
    .out_hit_mac(out_hit_mac), .out_hit_lease(out_hit_lease),
    .out_hit_expiry(out_hit_expiry), .out_removed_count(out_removed_count),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Mostly back-to-back, some short pauses, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(80, 9);
    return $urandom_range(300, 100);
  endfunction

  // Small address pool so that duplicates, hits and deletes are common
  function automatic logic [31:0] pick_ip();
    if ($urandom_range(99) >= 80) return $urandom();
    case ($urandom_range(7))
      0:       return '0;
      1:       return ALL_ONES_32;
      2:       return 32'h0A00_0001;
      3:       return 32'h0A00_0002;
      4:       return 32'hC0A8_0101;
      5:       return 32'hC0A8_01FE;
      6:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Times cluster in a narrow window so that ticks age out part of the table
  function automatic logic [31:0] pick_time(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(hi, lo);
    if (r < 90) return '0;
    if (r < 95) return ALL_ONES_32;
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_lease();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return ALL_ONES_32;
    return $urandom();
  endfunction

  function automatic logic [47:0] pick_mac();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return ALL_ONES_48;
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // Episodes: fill, mixed churn, lookup and delete, aging
  function automatic logic [2:0] pick_mode(input int idx);
    int unsigned r;
    r = $urandom_range(99);
    case ((idx / EPISODE_LEN) % 4)
      0: begin
        if (idx % EPISODE_LEN == EPISODE_LEN - 1) return MODE_CLEAR;
        if (r < 88) return MODE_INSERT;
        if (r < 96) return MODE_LOOKUP;
        return MODE_DELETE;
      end
      1: begin
        if (r < 35) return MODE_INSERT;
        if (r < 60) return MODE_LOOKUP;
        if (r < 75) return MODE_DELETE;
        if (r < 87) return MODE_TICK;
        if (r < 90) return MODE_CLEAR;
      end
      2: begin
        if (r < 20) return MODE_INSERT;
        if (r < 55) return MODE_LOOKUP;
        if (r < 90) return MODE_DELETE;
        if (r < 96) return MODE_TICK;
      end
      default: begin
        if (r < 40) return MODE_INSERT;
        if (r < 60) return MODE_LOOKUP;
        if (r < 70) return MODE_DELETE;
        if (r < 95) return MODE_TICK;
        if (r < 98) return MODE_CLEAR;
      end
    endcase
    return 3'($urandom_range(MODE_LAST_UNUSED, MODE_FIRST_UNUSED));
  endfunction

  // Present one command, hold it while the block is busy, then drop start for a random gap if one is picked
  task automatic send_op(input logic [2:0] mode, input logic [31:0] ip,
                         input logic [47:0] mac, input logic [31:0] lease,
                         input logic [31:0] expiry, input logic [31:0] now);
    int unsigned gap;
    start         <= 1'b1;
    in_mode       <= mode;
    in_ip_addr    <= ip;
    in_mac_addr   <= mac;
    in_lease_secs <= lease;
    in_expiry_sec <= expiry;
    in_now_sec    <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [31:0] ip;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: misses and zero counts
    send_op(MODE_LOOKUP, '0, ALL_ONES_48, ALL_ONES_32, ALL_ONES_32, ALL_ONES_32);
    send_op(MODE_DELETE, ALL_ONES_32, '0, '0, '0, '0);
    send_op(MODE_TICK, '0, '0, '0, '0, ALL_ONES_32);
    send_op(MODE_CLEAR, '0, '0, '0, '0, '0);

    // Extreme field values, then a duplicated address
    send_op(MODE_INSERT, '0, '0, '0, '0, ALL_ONES_32);
    send_op(MODE_INSERT, ALL_ONES_32, ALL_ONES_48, ALL_ONES_32, ALL_ONES_32, '0);
    send_op(MODE_INSERT, 32'h0A00_0001, 48'h0200_0000_0001, 32'd3600, 32'd100, '0);
    send_op(MODE_INSERT, 32'h0A00_0001, 48'h0200_0000_0002, 32'd7200, 32'd200, '0);
    send_op(MODE_LOOKUP, 32'h0A00_0001, '0, '0, '0, '0);
    send_op(MODE_LOOKUP, '0, '0, '0, '0, '0);
    send_op(MODE_LOOKUP, ALL_ONES_32, '0, '0, '0, '0);

    // Delete removes the newest duplicate; a reinsert lands in the freed slot
    send_op(MODE_DELETE, 32'h0A00_0001, '0, '0, '0, '0);
    send_op(MODE_LOOKUP, 32'h0A00_0001, '0, '0, '0, '0);
    send_op(MODE_INSERT, 32'h0A00_0001, 48'h0200_0000_0003, 32'd60, 32'd200, '0);
    send_op(MODE_LOOKUP, 32'h0A00_0001, '0, '0, '0, '0);

    // Unused modes
    for (int m = MODE_FIRST_UNUSED; m <= MODE_LAST_UNUSED; m++)
      send_op(3'(m), pick_ip(), pick_mac(), pick_lease(), $urandom(), $urandom());

    // Aging at the time extremes, with expiry equal to now
    send_op(MODE_TICK, '0, '0, '0, '0, '0);
    send_op(MODE_TICK, '0, '0, '0, '0, 32'd150);
    send_op(MODE_TICK, '0, '0, '0, '0, ALL_ONES_32 - 32'd1);
    send_op(MODE_CLEAR, '0, '0, '0, '0, '0);
    send_op(MODE_LOOKUP, ALL_ONES_32, '0, '0, '0, '0);

    // Random episodes
    for (int i = 0; i < RANDOM_OPS; i++) begin
      ip = pick_ip();
      send_op(pick_mode(i), ip, pick_mac(), pick_lease(), pick_time(1000, 1200),
              pick_time(990, 1210));
    end

    // Drain and give the verdict
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
